[hdl/iass_pkg.sv]
// Package for the chat line style stripper: widths, codes, shared types.
// No dependencies.
package iass_pkg;

  localparam int MaxText     = 512;
  localparam int MaxSegments = 64;
  localparam int MaxSgr      = 16;
  localparam int SgrIdxW     = $clog2(MaxSgr);
  localparam int SgrCntW     = $clog2(MaxSgr + 1);
  localparam int TextCntW    = 10;
  localparam int SegCntW     = $clog2(MaxSegments + 1);
  localparam int FifoDepth   = 4;
  localparam int FifoPtrW    = $clog2(FifoDepth);

  localparam logic [3:0] BaseNone   = 4'd8;
  localparam logic [6:0] IdxDefault = 7'd99;

  localparam logic [1:0] RkText = 2'd0;
  localparam logic [1:0] RkSeg  = 2'd1;
  localparam logic [1:0] RkSum  = 2'd2;

  localparam logic [2:0] KDefault = 3'd0;
  localparam logic [2:0] KXterm   = 3'd1;
  localparam logic [2:0] KMirc    = 3'd2;
  localparam logic [2:0] KRgb     = 3'd3;
  localparam logic [2:0] KLiteral = 3'd4;

  localparam logic CfgDefFg = 1'b0;

  typedef enum logic [3:0] {
    M_NORMAL, M_FG0, M_FG1, M_FGDONE, M_BG0, M_BG1, M_ESC, M_OSC, M_CHARSET, M_CSI
  } scan_mode_e;

  typedef enum logic [1:0] {
    B_IDLE, B_SGR, B_OUT
  } back_state_e;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       byte_valid;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
  } color_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  text_byte;
    logic [9:0]  seg_offset;
    color_t      fg;
    color_t      bg;
    logic [2:0]  style_flags;
    logic        non_ascii;
    logic        last;
  } result_t;

endpackage

[hdl/iass_fifo.sv]
// Short input queue between the input port and the back part.
// Depends on iass_pkg.
module iass_fifo import iass_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     wr_i,
  input  in_item_t wdata_i,
  output logic     full_o,
  input  logic     rd_i,
  output in_item_t rdata_o,
  output logic     empty_o
);

  in_item_t              mem_q [FifoDepth];
  logic [FifoPtrW-1:0]   wptr_q, rptr_q;
  logic [FifoPtrW:0]     cnt_q;

  assign full_o  = (cnt_q == (FifoPtrW+1)'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  // advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_i) wptr_q <= wptr_q + 1'b1;
      if (rd_i) rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_q + (FifoPtrW+1)'(wr_i) - (FifoPtrW+1)'(rd_i);
    end
  end

  // hold items
  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wptr_q] <= wdata_i;
  end

endmodule

[hdl/iass_back.sv]
// Back part: scanner state machine, SGR walk over stored parameters, result queue.
// Depends on iass_pkg.
module iass_back import iass_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] def_fg_i,
  input  logic [31:0] def_bg_i,
  input  logic        in_empty_i,
  input  in_item_t    in_item_i,
  output logic        in_pop_o,
  output logic        res_empty_o,
  output result_t     res_o,
  input  logic        res_pop_i
);

  // state
  scan_mode_e          mode_q, mode_d;
  color_t              sfg_q, sfg_d, sbg_q, sbg_d;
  logic [2:0]          attr_q, attr_d;
  logic [3:0]          basic_q, basic_d;
  logic                rev_q, rev_d;
  logic [6:0]          cdig_q, cdig_d;
  logic [6:0]          pfg_q, pfg_d;
  logic [15:0]         acc_q, acc_d;
  logic [15:0]         prm_q [MaxSgr];
  logic [SgrCntW-1:0]  scnt_q, scnt_d;
  logic [TextCntW-1:0] sstart_q, sstart_d, tcnt_q, tcnt_d;
  logic [SegCntW-1:0]  segc_q, segc_d;
  logic                hb_q, hb_d;
  back_state_e         st_q, st_d;
  logic [SgrCntW-1:0]  k_q, k_d;
  in_item_t            cur_q;
  logic                pw_en;
  logic [SgrIdxW-1:0]  pw_idx;
  logic [15:0]         pw_val;

  // staged results of the current item
  result_t             rb_q [3];
  logic [1:0]          rn_q;
  logic [1:0]          ro_q;
  result_t             rb_d [3];
  logic [1:0]          rn_d;

  assign res_empty_o = (st_q != B_OUT);
  assign res_o       = rb_q[ro_q];

  // walk step helpers
  function automatic logic [7:0] clampb(input logic [15:0] v);
    return (v > 16'd255) ? 8'hFF : v[7:0];
  endfunction

  function automatic logic [15:0] prm_at(input logic [SgrCntW-1:0] i,
                                         input logic [15:0] p [MaxSgr]);
    return p[i[SgrIdxW-1:0]];
  endfunction

  // main combinational step
  always_comb begin
    result_t     r;
    color_t      fgc, bgc, col;
    logic        dig, fin, sgr_go, redo, endl;
    logic [7:0]  c;
    logic [3:0]  d;
    logic [6:0]  fgi, bgi;
    logic        do_color;
    logic [15:0] p, md;
    logic [19:0] accx;
    logic        stop;
    logic [SgrCntW-1:0] step;

    mode_d = mode_q; sfg_d = sfg_q; sbg_d = sbg_q; attr_d = attr_q; basic_d = basic_q;
    rev_d = rev_q; cdig_d = cdig_q; pfg_d = pfg_q; acc_d = acc_q; scnt_d = scnt_q;
    sstart_d = sstart_q; tcnt_d = tcnt_q; segc_d = segc_q; hb_d = hb_q;
    st_d = st_q; k_d = k_q; rn_d = rn_q; rb_d = rb_q;
    in_pop_o = 1'b0; pw_en = 1'b0; pw_idx = '0; pw_val = acc_q;
    r = '0; fgc = '0; bgc = '0; col = '0; dig = 1'b0; fin = 1'b0; sgr_go = 1'b0;
    redo = 1'b0; endl = 1'b0; c = cur_q.char_byte; d = '0; fgi = IdxDefault;
    bgi = IdxDefault; do_color = 1'b0; p = '0; md = '0; accx = '0; stop = 1'b0;
    step = '0;

    case (st_q)
      B_IDLE: begin
        if (!in_empty_i) begin
          in_pop_o = 1'b1;
          c = in_item_i.char_byte;
          rn_d = '0;
          dig = (c >= "0") && (c <= "9");
          d = dig ? 4'(c - "0") : 4'd0;
          if (in_item_i.byte_valid) begin
            case (mode_q)
              M_FG0: begin
                if (dig) begin cdig_d = 7'(d); mode_d = M_FG1; end
                else if (c == ",") begin pfg_d = IdxDefault; mode_d = M_BG0; end
                else begin do_color = 1'b1; redo = 1'b1; end
              end
              M_FG1: begin
                if (dig) begin
                  pfg_d = 7'(cdig_q * 7'd10 + 7'(d)); mode_d = M_FGDONE;
                end else if (c == ",") begin pfg_d = cdig_q; mode_d = M_BG0; end
                else begin do_color = 1'b1; fgi = cdig_q; redo = 1'b1; end
              end
              M_FGDONE: begin
                if (c == ",") mode_d = M_BG0;
                else begin do_color = 1'b1; fgi = pfg_q; redo = 1'b1; end
              end
              M_BG0: begin
                if (dig) begin cdig_d = 7'(d); mode_d = M_BG1; end
                else begin do_color = 1'b1; fgi = pfg_q; redo = 1'b1; end
              end
              M_BG1: begin
                do_color = 1'b1; fgi = pfg_q;
                if (dig) bgi = 7'(cdig_q * 7'd10 + 7'(d));
                else begin bgi = cdig_q; redo = 1'b1; end
              end
              M_ESC: begin
                if (c == "]") mode_d = M_OSC;
                else if (c == "[") begin mode_d = M_CSI; scnt_d = '0; acc_d = '0; end
                else if (c == "(" || c == ")" || c == "#") mode_d = M_CHARSET;
                else mode_d = M_NORMAL;
              end
              M_OSC: if (c == 8'h07) mode_d = M_NORMAL;
              M_CHARSET: mode_d = M_NORMAL;
              M_CSI: begin
                if (dig) begin
                  accx = 20'(acc_q) * 20'd10 + 20'(d);
                  acc_d = (accx > 20'd65535) ? 16'hFFFF : accx[15:0];
                end else if (c == ";" || c == ":") begin
                  fin = 1'b1;
                end else if (c >= 8'h20 && c <= 8'h3F) begin
                  // intermediate: skip
                end else if (c >= 8'h40 && c <= 8'h7E) begin
                  mode_d = M_NORMAL;
                  if (c == "m") begin fin = 1'b1; sgr_go = 1'b1; end
                end else redo = 1'b1;
              end
              default: redo = 1'b1;
            endcase
          end
          if (do_color) begin
            sfg_d = (fgi != IdxDefault) ? color_t'{KMirc, 32'(fgi)} : color_t'{KDefault, 32'd0};
            basic_d = BaseNone;
            if (bgi != IdxDefault) sbg_d = color_t'{KMirc, 32'(bgi)};
            sstart_d = tcnt_q;
            mode_d = M_NORMAL;
          end
          // push parameter
          if (fin) begin
            if (scnt_q < SgrCntW'(MaxSgr)) begin
              pw_en = 1'b1; pw_idx = scnt_q[SgrIdxW-1:0]; scnt_d = scnt_q + 1'b1;
            end
            acc_d = '0;
          end
          // plain byte handling
          if (redo) begin
            mode_d = M_NORMAL;
            if (c == 8'h02 || c == 8'h16 || c == 8'h1F || c == 8'h0F || c == 8'h03 ||
                c == 8'h1B) begin
              if (tcnt_q > sstart_d && segc_q < SegCntW'(MaxSegments)) begin
                fgc = sfg_d; bgc = sbg_d;
                if (rev_q) begin
                  fgc = (sbg_d.kind == KDefault) ? color_t'{KLiteral, def_bg_i} : sbg_d;
                  bgc = (sfg_d.kind == KDefault) ? color_t'{KLiteral, def_fg_i} : sfg_d;
                end
                r = '0; r.result_kind = RkSeg; r.seg_offset = sstart_d;
                r.fg = fgc; r.bg = bgc; r.style_flags = attr_q;
                rb_d[0] = r; rn_d = 2'd1; segc_d = segc_q + 1'b1;
              end
              if (c == 8'h02) attr_d = attr_q ^ 3'b001;
              else if (c == 8'h16) attr_d = attr_q ^ 3'b010;
              else if (c == 8'h1F) attr_d = attr_q ^ 3'b100;
              else if (c == 8'h0F) begin
                sfg_d = '0; sbg_d = '0; attr_d = '0; basic_d = BaseNone; rev_d = 1'b0;
              end else if (c == 8'h03) mode_d = M_FG0;
              else mode_d = M_ESC;
              sstart_d = tcnt_q;
            end else if (tcnt_q < TextCntW'(MaxText)) begin
              r = '0; r.result_kind = RkText; r.text_byte = c;
              rb_d[0] = r; rn_d = 2'd1;
              tcnt_d = tcnt_q + 1'b1;
              if (c[7]) hb_d = 1'b1;
            end
          end
          if (sgr_go) begin
            st_d = B_SGR; k_d = '0;
          end else begin
            endl = in_item_i.line_end;
          end
        end
      end

      B_SGR: begin
        // one parameter (or one extended group) per cycle
        stop = 1'b0; step = SgrCntW'(1);
        if (k_q >= scnt_q) stop = 1'b1;
        else begin
          p = prm_at(k_q, prm_q);
          if (p == 16'd0) begin
            sfg_d = '0; sbg_d = '0; attr_d = '0; basic_d = BaseNone; rev_d = 1'b0;
          end else if (p == 16'd1) begin
            attr_d[0] = 1'b1;
            if (basic_q < 4'd8) sfg_d = color_t'{KXterm, 32'(basic_q) + 32'd8};
          end else if (p == 16'd3) attr_d[1] = 1'b1;
          else if (p == 16'd4) attr_d[2] = 1'b1;
          else if (p == 16'd7) rev_d = 1'b1;
          else if (p == 16'd22) begin
            attr_d[0] = 1'b0;
            if (basic_q < 4'd8) sfg_d = color_t'{KXterm, 32'(basic_q)};
          end else if (p == 16'd23) attr_d[1] = 1'b0;
          else if (p == 16'd24) attr_d[2] = 1'b0;
          else if (p == 16'd27) rev_d = 1'b0;
          else if (p == 16'd39) begin sfg_d = '0; basic_d = BaseNone; end
          else if (p == 16'd49) sbg_d = '0;
          else if (p == 16'd38 || p == 16'd48) begin
            if (k_q + 1'b1 >= scnt_q) stop = 1'b1;
            else begin
              md = prm_at(k_q + 1'b1, prm_q);
              if (md == 16'd5) begin
                if (k_q + 2'd2 >= scnt_q) stop = 1'b1;
                else begin
                  col = color_t'{KXterm, 32'(clampb(prm_at(k_q + 2'd2, prm_q)))};
                  step = SgrCntW'(3);
                end
              end else if (md == 16'd2) begin
                if ((SgrCntW+1)'(k_q) + 4 >= (SgrCntW+1)'(scnt_q)) stop = 1'b1;
                else begin
                  col = color_t'{KRgb, {8'd0, clampb(prm_at(k_q + 2'd2, prm_q)),
                                 clampb(prm_at(k_q + 2'd3, prm_q)),
                                 clampb(prm_at(SgrCntW'(k_q + 3'd4), prm_q))}};
                  step = SgrCntW'(5);
                end
              end else stop = 1'b1;
              if (!stop) begin
                if (p == 16'd38) begin sfg_d = col; basic_d = BaseNone; end
                else sbg_d = col;
              end
            end
          end else if (p >= 16'd30 && p <= 16'd37) begin
            basic_d = 4'(p - 16'd30);
            sfg_d = color_t'{KXterm, attr_q[0] ? 32'(p - 16'd22) : 32'(p - 16'd30)};
          end else if (p >= 16'd40 && p <= 16'd47) sbg_d = color_t'{KXterm, 32'(p - 16'd40)};
          else if (p >= 16'd90 && p <= 16'd97) begin
            sfg_d = color_t'{KXterm, 32'(p - 16'd82)}; basic_d = BaseNone;
          end else if (p >= 16'd100 && p <= 16'd107)
            sbg_d = color_t'{KXterm, 32'(p - 16'd92)};
        end
        // k may step past count; widen to avoid wrap
        if (stop || ((SgrCntW+1)'(k_q) + (SgrCntW+1)'(step) >= (SgrCntW+1)'(scnt_q)))
        begin
          k_d = '0;
          endl = cur_q.line_end;
          st_d = B_IDLE;
        end else k_d = k_q + step;
      end

      B_OUT: begin
        if (res_pop_i && ro_q == rn_q - 1'b1) st_d = B_IDLE;
      end

      default: st_d = B_IDLE;
    endcase

    // line end: flush, summary, clear
    if (endl) begin
      if (tcnt_d > sstart_d && segc_d < SegCntW'(MaxSegments)) begin
        fgc = sfg_d; bgc = sbg_d;
        if (rev_d) begin
          fgc = (sbg_d.kind == KDefault) ? color_t'{KLiteral, def_bg_i} : sbg_d;
          bgc = (sfg_d.kind == KDefault) ? color_t'{KLiteral, def_fg_i} : sfg_d;
        end
        r = '0; r.result_kind = RkSeg; r.seg_offset = sstart_d;
        r.fg = fgc; r.bg = bgc; r.style_flags = attr_d;
        rb_d[rn_d] = r; rn_d = rn_d + 1'b1;
      end
      r = '0; r.result_kind = RkSum; r.non_ascii = hb_d;
      rb_d[rn_d] = r; rn_d = rn_d + 1'b1;
      mode_d = M_NORMAL; sfg_d = '0; sbg_d = '0; attr_d = '0; basic_d = BaseNone;
      rev_d = 1'b0; cdig_d = '0; pfg_d = IdxDefault; acc_d = '0; scnt_d = '0;
      sstart_d = '0; tcnt_d = '0; segc_d = '0; hb_d = 1'b0;
    end
    // mark last and go show results
    if ((st_q == B_IDLE && !in_empty_i && st_d == B_IDLE) ||
        (st_q == B_SGR && st_d == B_IDLE)) begin
      if (rn_d != '0) begin
        rb_d[rn_d - 1'b1].last = 1'b1;
        st_d = B_OUT;
      end
    end
  end

  // registers with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_NORMAL; sfg_q <= '0; sbg_q <= '0; attr_q <= '0; basic_q <= BaseNone;
      rev_q <= 1'b0; cdig_q <= '0; pfg_q <= IdxDefault; acc_q <= '0; scnt_q <= '0;
      sstart_q <= '0; tcnt_q <= '0; segc_q <= '0; hb_q <= 1'b0;
      st_q <= B_IDLE; k_q <= '0; rn_q <= '0; ro_q <= '0;
    end else begin
      mode_q <= mode_d; sfg_q <= sfg_d; sbg_q <= sbg_d; attr_q <= attr_d;
      basic_q <= basic_d; rev_q <= rev_d; cdig_q <= cdig_d; pfg_q <= pfg_d;
      acc_q <= acc_d; scnt_q <= scnt_d; sstart_q <= sstart_d; tcnt_q <= tcnt_d;
      segc_q <= segc_d; hb_q <= hb_d; st_q <= st_d; k_q <= k_d; rn_q <= rn_d;
      if (st_q != B_OUT) ro_q <= '0;
      else if (res_pop_i) ro_q <= ro_q + 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_pop_o) cur_q <= in_item_i;
    if (pw_en) prm_q[pw_idx] <= pw_val;
    rb_q <= rb_d;
  end

`ifndef NO_ASSERTIONS
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_pop_o |-> st_q == B_IDLE) else $error("input taken while busy");
  a_out_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == B_OUT |-> rn_q != '0 && ro_q < rn_q) else $error("bad result count");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == B_OUT |-> (res_o.last == (ro_q == rn_q - 1'b1))) else $error("last flag");
  a_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tcnt_q <= TextCntW'(MaxText)) else $error("text count overflow");
`endif

endmodule

[hdl/irc_ansi_style_stripper_core.sv]
// Top level of the chat line style stripper: input queue plus back part.
// Depends on iass_pkg, iass_fifo, iass_back.
//   channel   direction  handshake                 payload
//   input     in         push / full               char_byte_i byte_valid_i line_end_i
//   result    out        empty / pop               result_kind_o .. last_o
//   config    in         cfg_valid_i / cfg_ready_o cfg_index_i cfg_data_i
// An item is taken from the queue in B_IDLE and its results are then popped one at a time
// in B_OUT; an SGR final byte first walks each parameter or extended colour group in B_SGR.
// The four-entry input queue keeps accepting until full while results wait to be popped.
// Reset clears all line state; stored SGR values are undefined until written.
module irc_ansi_style_stripper_core import iass_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  char_byte_i,
  input  logic        byte_valid_i,
  input  logic        line_end_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  text_byte_o,
  output logic [9:0]  seg_offset_o,
  output logic [2:0]  fg_kind_o,
  output logic [31:0] fg_value_o,
  output logic [2:0]  bg_kind_o,
  output logic [31:0] bg_value_o,
  output logic [2:0]  style_flags_o,
  output logic        non_ascii_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [31:0] def_fg_q, def_bg_q;
  in_item_t    wi, ri;
  logic        q_empty, q_pop;
  result_t     res;

  assign cfg_ready_o = 1'b1;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_fg_q <= '0;
      def_bg_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgDefFg) def_fg_q <= cfg_data_i;
      else def_bg_q <= cfg_data_i;
    end
  end

  assign wi = '{char_byte: char_byte_i, byte_valid: byte_valid_i, line_end: line_end_i};

  iass_fifo u_fifo (
    .clk_i, .rst_ni, .wr_i(push && !full), .wdata_i(wi), .full_o(full),
    .rd_i(q_pop), .rdata_o(ri), .empty_o(q_empty)
  );

  iass_back u_back (
    .clk_i, .rst_ni, .def_fg_i(def_fg_q), .def_bg_i(def_bg_q),
    .in_empty_i(q_empty), .in_item_i(ri), .in_pop_o(q_pop),
    .res_empty_o(empty), .res_o(res), .res_pop_i(pop)
  );

  assign result_kind_o = res.result_kind;
  assign text_byte_o   = res.text_byte;
  assign seg_offset_o  = res.seg_offset;
  assign fg_kind_o     = res.fg.kind;
  assign fg_value_o    = res.fg.value;
  assign bg_kind_o     = res.bg.kind;
  assign bg_value_o    = res.bg.value;
  assign style_flags_o = res.style_flags;
  assign non_ascii_o   = res.non_ascii;
  assign last_o        = res.last;

endmodule

[verif/testbench.sv]
// Testbench for irc_ansi_style_stripper_core: random and directed chat lines,
// checked result by result against a behavioural predictor kept in this file.
// Depends on iass_pkg and the RTL of the core.
`timescale 1ns / 100ps

module testbench;
  import iass_pkg::*;

  localparam logic CfgDefBg   = 1'b1;
  localparam int   WatchLimit = 5000;
  localparam int   LongHold   = 90;

  typedef struct {
    logic [7:0] chr;
    logic       vld;
    logic       eol;
  } line_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  char_byte_i = '0;
  logic        byte_valid_i = 1'b0;
  logic        line_end_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  result_kind_o;
  logic [7:0]  text_byte_o;
  logic [9:0]  seg_offset_o;
  logic [2:0]  fg_kind_o, bg_kind_o, style_flags_o;
  logic [31:0] fg_value_o, bg_value_o;
  logic        non_ascii_o, last_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [31:0] cfg_data_i = '0;

  irc_ansi_style_stripper_core u_top (.*);

  always #10 clk_i = ~clk_i;

  // Line items waiting to be sent, and results still owed by the block
  line_item_t line_q[$];
  result_t    owed_q[$];
  int         errors = 0;
  int         hold_req = 0;

  // ---------------- style predictor ----------------
  logic [31:0] theme_fg = '0, theme_bg = '0;
  scan_mode_e  mode;
  color_t      cur_fg, cur_bg;
  logic [2:0]  attrs;
  int          basic_fg, rev, digs, pend_fg, acc, nprm;
  int          prm[MaxSgr];
  int          seg_base, txt_cnt, segs, hi_seen, step_n;

  function automatic color_t col(logic [2:0] k, logic [31:0] v);
    color_t c;
    c.kind = k;
    c.value = v;
    return c;
  endfunction

  task automatic owe(logic [1:0] k, logic [7:0] tb, logic [9:0] off, color_t f, color_t b,
                     logic [2:0] fl, logic na);
    result_t r;
    if (step_n >= 3) return;
    r = '0;
    r.result_kind = k;
    r.text_byte = tb;
    r.seg_offset = off;
    r.fg = f;
    r.bg = b;
    r.style_flags = fl;
    r.non_ascii = na;
    owed_q.push_back(r);
    step_n++;
  endtask

  task automatic style_clear();
    cur_fg = col(KDefault, 0);
    cur_bg = col(KDefault, 0);
    attrs = '0;
    basic_fg = 8;
    rev = 0;
  endtask

  task automatic line_clear();
    mode = M_NORMAL;
    style_clear();
    digs = 0;
    pend_fg = 99;
    acc = 0;
    nprm = 0;
    seg_base = 0;
    txt_cnt = 0;
    segs = 0;
    hi_seen = 0;
  endtask

  // Close the current run as a segment, swapping colours under reverse video
  task automatic close_run();
    color_t f, b;
    if (txt_cnt <= seg_base || segs >= MaxSegments) return;
    f = cur_fg;
    b = cur_bg;
    if (rev != 0) begin
      f = (cur_bg.kind == KDefault) ? col(KLiteral, theme_bg) : cur_bg;
      b = (cur_fg.kind == KDefault) ? col(KLiteral, theme_fg) : cur_fg;
    end
    owe(RkSeg, 0, seg_base, f, b, attrs, 0);
    segs++;
  endtask

  function automatic int sat8(int v);
    return (v > 255) ? 255 : v;
  endfunction

  task automatic run_sgr();
    int k, p, md;
    color_t c;
    k = 0;
    while (k < nprm) begin
      p = prm[k];
      if (p == 0) style_clear();
      else if (p == 1) begin
        attrs[0] = 1'b1;
        if (basic_fg < 8) cur_fg = col(KXterm, basic_fg + 8);
      end else if (p == 3) attrs[1] = 1'b1;
      else if (p == 4) attrs[2] = 1'b1;
      else if (p == 7) rev = 1;
      else if (p == 22) begin
        attrs[0] = 1'b0;
        if (basic_fg < 8) cur_fg = col(KXterm, basic_fg);
      end else if (p == 23) attrs[1] = 1'b0;
      else if (p == 24) attrs[2] = 1'b0;
      else if (p == 27) rev = 0;
      else if (p == 39) begin
        cur_fg = col(KDefault, 0);
        basic_fg = 8;
      end else if (p == 49) cur_bg = col(KDefault, 0);
      else if (p == 38 || p == 48) begin
        if (k + 1 >= nprm) return;
        k++;
        md = prm[k];
        if (md == 5) begin
          if (k + 1 >= nprm) return;
          k++;
          c = col(KXterm, sat8(prm[k]));
        end else if (md == 2) begin
          if (k + 3 >= nprm) return;
          c = col(KRgb, (sat8(prm[k+1]) << 16) | (sat8(prm[k+2]) << 8) | sat8(prm[k+3]));
          k += 3;
        end else return;
        if (p == 38) begin
          cur_fg = c;
          basic_fg = 8;
        end else cur_bg = c;
      end else if (p >= 30 && p <= 37) begin
        basic_fg = p - 30;
        cur_fg = col(KXterm, attrs[0] ? basic_fg + 8 : basic_fg);
      end else if (p >= 40 && p <= 47) cur_bg = col(KXterm, p - 40);
      else if (p >= 90 && p <= 97) begin
        cur_fg = col(KXterm, p - 82);
        basic_fg = 8;
      end else if (p >= 100 && p <= 107) cur_bg = col(KXterm, p - 92);
      k++;
    end
  endtask

  task automatic set_colours(int fi, int bi);
    cur_fg = (fi != 99) ? col(KMirc, fi) : col(KDefault, 0);
    basic_fg = 8;
    if (bi != 99) cur_bg = col(KMirc, bi);
    seg_base = txt_cnt;
    mode = M_NORMAL;
  endtask

  task automatic store_param();
    if (nprm < MaxSgr) begin
      prm[nprm] = acc;
      nprm++;
    end
    acc = 0;
  endtask

  task automatic plain_byte(logic [7:0] c);
    mode = M_NORMAL;
    if (c == 8'h02 || c == 8'h16 || c == 8'h1F || c == 8'h0F || c == 8'h03 || c == 8'h1B)
    begin
      close_run();
      case (c)
        8'h02: attrs[0] = ~attrs[0];
        8'h16: attrs[1] = ~attrs[1];
        8'h1F: attrs[2] = ~attrs[2];
        8'h0F: style_clear();
        8'h03: mode = M_FG0;
        default: mode = M_ESC;
      endcase
      seg_base = txt_cnt;
      return;
    end
    if (txt_cnt < MaxText) begin
      owe(RkText, c, 0, col(0, 0), col(0, 0), 0, 0);
      txt_cnt++;
      if (c[7]) hi_seen = 1;
    end
  endtask

  task automatic scan(logic [7:0] c);
    logic dig;
    int d;
    dig = (c >= "0" && c <= "9");
    d = dig ? int'(c) - 48 : 0;
    case (mode)
      M_FG0:
        if (dig) begin
          digs = d;
          mode = M_FG1;
        end else if (c == ",") begin
          pend_fg = 99;
          mode = M_BG0;
        end else begin
          set_colours(99, 99);
          plain_byte(c);
        end
      M_FG1:
        if (dig) begin
          pend_fg = digs * 10 + d;
          mode = M_FGDONE;
        end else if (c == ",") begin
          pend_fg = digs;
          mode = M_BG0;
        end else begin
          set_colours(digs, 99);
          plain_byte(c);
        end
      M_FGDONE:
        if (c == ",") mode = M_BG0;
        else begin
          set_colours(pend_fg, 99);
          plain_byte(c);
        end
      M_BG0:
        if (dig) begin
          digs = d;
          mode = M_BG1;
        end else begin
          set_colours(pend_fg, 99);
          plain_byte(c);
        end
      M_BG1:
        if (dig) set_colours(pend_fg, digs * 10 + d);
        else begin
          set_colours(pend_fg, digs);
          plain_byte(c);
        end
      M_ESC:
        if (c == "]") mode = M_OSC;
        else if (c == "[") begin
          mode = M_CSI;
          nprm = 0;
          acc = 0;
        end else if (c == "(" || c == ")" || c == "#") mode = M_CHARSET;
        else mode = M_NORMAL;
      M_OSC:
        if (c == 8'h07) mode = M_NORMAL;
      M_CHARSET:
        mode = M_NORMAL;
      M_CSI:
        if (dig) begin
          acc = acc * 10 + d;
          if (acc > 65535) acc = 65535;
        end else if (c == ";" || c == ":") store_param();
        else if (c >= 8'h20 && c <= 8'h3F) begin
          // parameter or intermediate byte: skip
        end else if (c >= 8'h40 && c <= 8'h7E) begin
          if (c == "m") begin
            store_param();
            run_sgr();
          end
          mode = M_NORMAL;
        end else plain_byte(c);
      default:
        plain_byte(c);
    endcase
  endtask

  task automatic predict_item(logic [7:0] c, logic v, logic e);
    step_n = 0;
    if (v) scan(c);
    if (e) begin
      close_run();
      owe(RkSum, 0, 0, col(0, 0), col(0, 0), 0, hi_seen[0]);
      line_clear();
    end
    if (step_n > 0) owed_q[owed_q.size()-1].last = 1'b1;
  endtask

  // ---------------- sender ----------------
  int  tx_gap = 0;
  logic in_taken = 1'b0;

  always @(negedge clk_i) begin
    logic nxt;
    line_item_t it;
    nxt = push;
    if (!push || in_taken) begin
      nxt = 1'b0;
      if (tx_gap > 0) tx_gap <= tx_gap - 1;
      else if (line_q.size() > 0) begin
        it = line_q.pop_front();
        char_byte_i <= it.chr;
        byte_valid_i <= it.vld;
        line_end_i <= it.eol;
        nxt = 1'b1;
        tx_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      end
    end
    push <= nxt;
  end

  // ---------------- receiver ----------------
  int rx_gap = 0, long_cnt = 0, hold_seen = 0;
  logic out_taken = 1'b0;

  always @(negedge clk_i) begin
    logic nxt;
    nxt = pop;
    if (long_cnt > 0) begin
      long_cnt <= long_cnt - 1;
      nxt = 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      long_cnt <= LongHold;
      nxt = 1'b0;
    end else if (out_taken) begin
      rx_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      nxt = (rx_gap == 0);
    end else if (!pop) begin
      if (rx_gap > 0) rx_gap = rx_gap - 1;
      nxt = (rx_gap == 0);
    end
    pop <= nxt;
  end

  // ---------------- monitor and watchdog ----------------
  int quiet = 0;

  task automatic check_result();
    result_t w;
    if (owed_q.size() == 0) begin
      $display("%0t: unexpected result kind %0d", $time, result_kind_o);
      errors++;
      return;
    end
    w = owed_q.pop_front();
    if ({result_kind_o, text_byte_o, seg_offset_o, fg_kind_o, fg_value_o, bg_kind_o,
         bg_value_o, style_flags_o, non_ascii_o, last_o} !== w) begin
      errors++;
      $display("%0t: mismatch expected kind=%0d byte=%h off=%0d fg=%0d/%h bg=%0d/%h fl=%0d na=%0d last=%0d",
               $time, w.result_kind, w.text_byte, w.seg_offset, w.fg.kind, w.fg.value,
               w.bg.kind, w.bg.value, w.style_flags, w.non_ascii, w.last);
      $display("%0t:          actual kind=%0d byte=%h off=%0d fg=%0d/%h bg=%0d/%h fl=%0d na=%0d last=%0d",
               $time, result_kind_o, text_byte_o, seg_offset_o, fg_kind_o, fg_value_o,
               bg_kind_o, bg_value_o, style_flags_o, non_ascii_o, last_o);
    end
  endtask

  always @(posedge clk_i) begin
    in_taken <= push && !full;
    out_taken <= pop && !empty;
    if (push && !full) predict_item(char_byte_i, byte_valid_i, line_end_i);
    if (pop && !empty) check_result();
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o) || !rst_ni)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WatchLimit) begin
      $display("** irc_ansi_style_stripper_core: FAILED **");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  task automatic add(logic [7:0] c, logic v = 1'b1, logic e = 1'b0);
    line_item_t it;
    it.chr = c;
    it.vld = v;
    it.eol = e;
    line_q.push_back(it);
  endtask

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) add(s[i]);
  endtask

  task automatic end_line();
    if ($urandom_range(0, 1)) add($urandom_range(0, 255), 1'b1, 1'b1);
    else add($urandom_range(0, 255), 1'b0, 1'b1);
  endtask

  function automatic int sgr_value();
    int pick[] = '{0, 1, 3, 4, 7, 22, 23, 24, 27, 39, 49, 38, 48, 5, 2};
    case ($urandom_range(0, 5))
      0, 1: return pick[$urandom_range(0, pick.size() - 1)];
      2: return 30 + $urandom_range(0, 7) + 10 * $urandom_range(0, 1);
      3: return 90 + $urandom_range(0, 7) + 10 * $urandom_range(0, 1);
      4: return $urandom_range(0, 300);
      default: return $urandom_range(0, 99999);
    endcase
  endfunction

  task automatic add_sgr();
    int n;
    add(8'h1B);
    add("[");
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 19) : $urandom_range(0, 5);
    for (int i = 0; i < n; i++) begin
      // well-formed extended colour groups now and then
      case ($urandom_range(0, 5))
        0: add_str($sformatf("%0d;5;%0d", 38 + 10 * $urandom_range(0, 1),
                             $urandom_range(0, 300)));
        1: add_str($sformatf("%0d;2;%0d;%0d;%0d", 38 + 10 * $urandom_range(0, 1),
                             $urandom_range(0, 300), $urandom_range(0, 255),
                             $urandom_range(0, 260)));
        default: if ($urandom_range(0, 7) != 0) add_str($sformatf("%0d", sgr_value()));
      endcase
      if (i < n - 1) add($urandom_range(0, 5) == 0 ? ":" : ";");
    end
    case ($urandom_range(0, 9))
      0: add($urandom_range(8'h40, 8'h7E));
      1: add($urandom_range(0, 1) ? $urandom_range(0, 8'h1F) : $urandom_range(8'h7F, 8'hFF));
      2: add_str("?m");
      default: add("m");
    endcase
  endtask

  task automatic add_part();
    int n;
    case ($urandom_range(0, 11))
      0, 1, 2: begin
        n = $urandom_range(1, 4);
        repeat (n) add($urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                 : $urandom_range(8'h20, 8'h7E));
      end
      3: add($urandom_range(0, 3) == 0 ? 8'h0F : ($urandom_range(0, 1) ? 8'h02
             : ($urandom_range(0, 1) ? 8'h16 : 8'h1F)));
      4, 5: begin
        add(8'h03);
        case ($urandom_range(0, 5))
          0: add_str($sformatf("%0d", $urandom_range(0, 99)));
          1: add_str($sformatf("%0d,%0d", $urandom_range(0, 99), $urandom_range(0, 99)));
          2: add_str($sformatf(",%0d", $urandom_range(0, 99)));
          3: add_str($sformatf("%0d,", $urandom_range(0, 9)));
          4: add_str($sformatf("%02d,%02d", $urandom_range(0, 99), $urandom_range(0, 99)));
          default: ;
        endcase
      end
      6, 7: add_sgr();
      8: begin
        add(8'h1B);
        add("]");
        n = $urandom_range(0, 4);
        repeat (n) add($urandom_range(8'h20, 8'h7E));
        if ($urandom_range(0, 3) != 0) add(8'h07);
      end
      9: begin
        add(8'h1B);
        if ($urandom_range(0, 1)) begin
          add($urandom_range(0, 2) == 0 ? "(" : ($urandom_range(0, 1) ? ")" : "#"));
          add($urandom_range(0, 255));
        end else add($urandom_range(0, 255));
      end
      10: add($urandom_range(0, 255), 1'b0, 1'b0);
      default: add($urandom_range(0, 255));
    endcase
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CfgDefFg) theme_fg = val;
    else theme_bg = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic settle();
    while (line_q.size() > 0 || push || owed_q.size() > 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  initial begin
    int budget;
    logic [31:0] fgs[4], bgs[4];
    line_clear();
    for (int i = 0; i < MaxSgr; i++) prm[i] = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: toggles, colour codes, SGR extremes, reverse with defaults
    write_reg(CfgDefFg, 32'hFFFF_FFFF);
    write_reg(CfgDefBg, 32'h0000_0000);
    add_str("a\x02b\x0304,12c\x1b[7;38;2;300;0;255m");
    add(8'hFF);
    add_str("\x1b[99999;38;9m");
    add(8'h80, 1'b1, 1'b1);
    add(8'h00, 1'b0, 1'b1);
    settle();

    // Overflow line: more runs than the segment limit
    for (int i = 0; i < 66; i++) begin
      add("x");
      add(8'h16);
    end
    add("z", 1'b1, 1'b1);
    settle();

    // Random lines over several theme colour settings
    fgs = '{32'h0, 32'hFFFF_FFFF, $urandom, 32'h00AB_CDEF};
    bgs = '{32'hFFFF_FFFF, 32'h0, $urandom, 32'h8000_0001};
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CfgDefFg, fgs[ph]);
      write_reg(CfgDefBg, bgs[ph]);
      if (ph == 1) hold_req++;
      budget = line_q.size() + 30;
      while (line_q.size() < budget) begin
        int parts;
        parts = $urandom_range(1, 8);
        repeat (parts) add_part();
        end_line();
      end
      settle();
    end

    if (errors == 0) $display("** irc_ansi_style_stripper_core: PASSED **");
    else $display("** irc_ansi_style_stripper_core: FAILED **");
    $finish;
  end

endmodule
